FILE: src/gcdu_pkg.sv
`default_nettype none

package gcdu_pkg;

    // number of cordic micro-rotations per chain
    localparam int CORDIC_ITERATIONS = 24;

    // datapath widths
    localparam int CW = 36;   // cordic x and y
    localparam int ZW = 34;   // cordic angle accumulator
    localparam int RW = 36;   // square root remainder
    localparam int VW = 64;   // square root radicand

    // register positions along the pipeline
    localparam int ROT_BASE   = 4;
    localparam int ST_A       = ROT_BASE + CORDIC_ITERATIONS + 2;
    localparam int ST_ANGLE   = ST_A + 1 + 32 + CORDIC_ITERATIONS;
    localparam int PIPE_DEPTH = ST_ANGLE + 3;

    // angle and scale constants
    localparam logic signed [35:0] DEG90  = 36'sd754974720;
    localparam logic signed [35:0] DEG180 = 36'sd1509949440;
    localparam logic signed [35:0] DEG360 = 36'sd3019898880;
    localparam logic signed [62:0] RAD_PER_DEG_Q35 = 63'sd599690565;
    localparam logic signed [CW-1:0] CORDIC_INV_GAIN = 36'sd652032874;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic [31:0] PI_Q30 = 32'd3373259426;
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;
    localparam logic [33:0] DIST_MAX = 34'd13493037000;
    localparam logic [23:0] RADIUS_RESET = 24'd6371000;

    // arctangent of 2^-i in q2.30
    function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
        logic signed [ZW-1:0] r;
        unique case (i)
            5'd0:  r = 34'sd843314857;
            5'd1:  r = 34'sd497837829;
            5'd2:  r = 34'sd263043837;
            5'd3:  r = 34'sd133525159;
            5'd4:  r = 34'sd67021687;
            5'd5:  r = 34'sd33543516;
            5'd6:  r = 34'sd16775851;
            5'd7:  r = 34'sd8388437;
            5'd8:  r = 34'sd4194283;
            5'd9:  r = 34'sd2097149;
            5'd10: r = 34'sd1048576;
            5'd11: r = 34'sd524288;
            5'd12: r = 34'sd262144;
            5'd13: r = 34'sd131072;
            5'd14: r = 34'sd65536;
            5'd15: r = 34'sd32768;
            5'd16: r = 34'sd16384;
            5'd17: r = 34'sd8192;
            5'd18: r = 34'sd4096;
            5'd19: r = 34'sd2048;
            5'd20: r = 34'sd1024;
            5'd21: r = 34'sd512;
            5'd22: r = 34'sd256;
            5'd23: r = 34'sd128;
            5'd24: r = 34'sd64;
            5'd25: r = 34'sd32;
            5'd26: r = 34'sd16;
            5'd27: r = 34'sd8;
            5'd28: r = 34'sd4;
            5'd29: r = 34'sd2;
            5'd30: r = 34'sd1;
            5'd31: r = 34'sd0;
        endcase
        return r;
    endfunction

    // reduce degrees q8.23 into [-180, 180)
    function automatic logic signed [31:0] wrap_deg(input logic signed [33:0] d);
        logic signed [35:0] c;
        logic signed [35:0] r;
        r = 36'(d);
        for (int k = -2; k <= 2; k++) begin
            c = 36'(d) + 36'(k) * DEG360;
            if (c >= -DEG180 && c < DEG180)
                r = c;
        end
        return r[31:0];
    endfunction

endpackage

`default_nettype wire

FILE: src/gcdu_rot_cell.sv
`default_nettype none

module gcdu_rot_cell (
    input  wire logic                            clk,
    input  wire logic                            en,
    input  wire logic [4:0]                      step,
    input  wire logic signed [gcdu_pkg::CW-1:0]  x_in,
    input  wire logic signed [gcdu_pkg::CW-1:0]  y_in,
    input  wire logic signed [gcdu_pkg::ZW-1:0]  z_in,
    output logic signed [gcdu_pkg::CW-1:0]       x_out,
    output logic signed [gcdu_pkg::CW-1:0]       y_out,
    output logic signed [gcdu_pkg::ZW-1:0]       z_out
);

    logic signed [gcdu_pkg::CW-1:0] x_reg, y_reg, x_next, y_next;
    logic signed [gcdu_pkg::ZW-1:0] z_reg, z_next;
    logic signed [gcdu_pkg::CW-1:0] dx, dy;

    // one micro-rotation driven by the sign of the residual angle
    always_comb
    begin
        dx = y_in >>> step;
        dy = x_in >>> step;
        if (z_in >= 0)
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - gcdu_pkg::atan_q30(step);
        end
        else
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + gcdu_pkg::atan_q30(step);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

`default_nettype wire

FILE: src/gcdu_vec_cell.sv
`default_nettype none

module gcdu_vec_cell (
    input  wire logic                            clk,
    input  wire logic                            en,
    input  wire logic [4:0]                      step,
    input  wire logic signed [gcdu_pkg::CW-1:0]  x_in,
    input  wire logic signed [gcdu_pkg::CW-1:0]  y_in,
    input  wire logic signed [gcdu_pkg::ZW-1:0]  z_in,
    output logic signed [gcdu_pkg::CW-1:0]       x_out,
    output logic signed [gcdu_pkg::CW-1:0]       y_out,
    output logic signed [gcdu_pkg::ZW-1:0]       z_out
);

    logic signed [gcdu_pkg::CW-1:0] x_reg, y_reg, x_next, y_next;
    logic signed [gcdu_pkg::ZW-1:0] z_reg, z_next;
    logic signed [gcdu_pkg::CW-1:0] dx, dy;

    // one vectoring step driving y toward zero
    always_comb
    begin
        dx = y_in >>> step;
        dy = x_in >>> step;
        if (y_in >= 0)
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + gcdu_pkg::atan_q30(step);
        end
        else
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - gcdu_pkg::atan_q30(step);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

`default_nettype wire

FILE: src/gcdu_sqrt_cell.sv
`default_nettype none

module gcdu_sqrt_cell (
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire logic [gcdu_pkg::RW-1:0]    rem_in,
    input  wire logic [31:0]                root_in,
    input  wire logic [gcdu_pkg::VW-1:0]    v_in,
    output logic [gcdu_pkg::RW-1:0]         rem_out,
    output logic [31:0]                     root_out,
    output logic [gcdu_pkg::VW-1:0]         v_out
);

    logic [gcdu_pkg::RW-1:0] rem_reg, rem_next, rem_sh, trial;
    logic [31:0]             root_reg, root_next, root_sh;
    logic [gcdu_pkg::VW-1:0] v_reg;

    // one result digit: bring down two bits, try to subtract
    always_comb
    begin
        root_sh = {root_in[30:0], 1'b0};
        rem_sh  = {rem_in[gcdu_pkg::RW-3:0], v_in[gcdu_pkg::VW-1 -: 2]};
        trial   = gcdu_pkg::RW'({root_sh, 1'b1});
        if (rem_sh >= trial)
        begin
            rem_next  = rem_sh - trial;
            root_next = root_sh | 32'd1;
        end
        else
        begin
            rem_next  = rem_sh;
            root_next = root_sh;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            v_reg    <= {v_in[gcdu_pkg::VW-3:0], 2'b00};
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign v_out    = v_reg;

endmodule

`default_nettype wire

FILE: src/great_circle_distance_unit.sv
`default_nettype none

// throughput: one word per cycle while no finished result is held by result_stall
// every cordic step and square root digit is its own cell
// a stalled result freezes the whole pipeline, so input stall follows output stall
// reset clears all valid bits and sets the sphere radius to 6371000 m
// payload registers are not reset
module great_circle_distance_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               radius_we,
    input  wire logic [23:0]        radius_wdata,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire logic signed [30:0] first_lat,
    input  wire logic signed [31:0] first_lon,
    input  wire logic signed [30:0] second_lat,
    input  wire logic signed [31:0] second_lon,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic [31:0]             central_angle,
    output logic [33:0]             distance_m
);

    localparam int N  = gcdu_pkg::CORDIC_ITERATIONS;
    localparam int CW = gcdu_pkg::CW;
    localparam int ZW = gcdu_pkg::ZW;
    localparam int RW = gcdu_pkg::RW;
    localparam int VW = gcdu_pkg::VW;
    localparam int PD = gcdu_pkg::PIPE_DEPTH;

    localparam logic signed [62:0] RND29 = 63'sd1 <<< 28;
    localparam logic signed [62:0] RND28 = 63'sd1 <<< 27;
    localparam logic signed [63:0] RND30 = 64'sd1 <<< 29;
    localparam logic [55:0]        RND22 = 56'd1 << 21;

    logic adv;
    logic vld_reg [0:PD-1];
    logic [23:0] radius_reg;

    // pipeline moves unless a finished result is held
    assign adv          = !(vld_reg[PD-1] && result_stall);
    assign item_stall   = !adv;
    assign result_valid = vld_reg[PD-1];

    // radius register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= gcdu_pkg::RADIUS_RESET;
        else if (radius_we)
            radius_reg <= radius_wdata;
    end

    // valid bits along the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PD; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= item_valid;
            for (int k = 1; k < PD; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    // input word
    logic signed [30:0] lat1_reg, lat2_reg;
    logic signed [31:0] lon1_reg, lon2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lat1_reg <= first_lat;
            lon1_reg <= first_lon;
            lat2_reg <= second_lat;
            lon2_reg <= second_lon;
        end
    end

    // differences wrapped, latitudes folded into +-90 degrees
    logic signed [31:0] hl_next, hn_next, c1_next, c2_next;
    logic signed [31:0] hl_reg, hn_reg, c1_reg, c2_reg;
    logic signed [31:0] w1, w2;
    logic [1:0] neg_next, neg1_reg;

    always_comb
    begin
        hl_next = gcdu_pkg::wrap_deg(34'(lat2_reg) - 34'(lat1_reg));
        hn_next = gcdu_pkg::wrap_deg(34'(lon2_reg) - 34'(lon1_reg));
        w1 = gcdu_pkg::wrap_deg(34'(lat1_reg));
        w2 = gcdu_pkg::wrap_deg(34'(lat2_reg));
        neg_next = 2'b00;
        c1_next = w1;
        c2_next = w2;
        if (36'(w1) > gcdu_pkg::DEG90)
        begin
            c1_next = 32'(gcdu_pkg::DEG180 - 36'(w1));
            neg_next[0] = 1'b1;
        end
        else if (36'(w1) < -gcdu_pkg::DEG90)
        begin
            c1_next = 32'(-gcdu_pkg::DEG180 - 36'(w1));
            neg_next[0] = 1'b1;
        end
        if (36'(w2) > gcdu_pkg::DEG90)
        begin
            c2_next = 32'(gcdu_pkg::DEG180 - 36'(w2));
            neg_next[1] = 1'b1;
        end
        else if (36'(w2) < -gcdu_pkg::DEG90)
        begin
            c2_next = 32'(-gcdu_pkg::DEG180 - 36'(w2));
            neg_next[1] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hl_reg   <= hl_next;
            hn_reg   <= hn_next;
            c1_reg   <= c1_next;
            c2_reg   <= c2_next;
            neg1_reg <= neg_next;
        end
    end

    // degrees to radians products
    logic signed [62:0] phl_reg, phn_reg, pc1_reg, pc2_reg;
    logic [1:0] neg2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            phl_reg  <= 63'(hl_reg) * gcdu_pkg::RAD_PER_DEG_Q35;
            phn_reg  <= 63'(hn_reg) * gcdu_pkg::RAD_PER_DEG_Q35;
            pc1_reg  <= 63'(c1_reg) * gcdu_pkg::RAD_PER_DEG_Q35;
            pc2_reg  <= 63'(c2_reg) * gcdu_pkg::RAD_PER_DEG_Q35;
            neg2_reg <= neg1_reg;
        end
    end

    // rounded radians, half angles for the differences
    logic signed [ZW-1:0] ang_reg [0:3];
    logic [1:0] neg3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ang_reg[0] <= ZW'((phl_reg + RND29) >>> 29);
            ang_reg[1] <= ZW'((phn_reg + RND29) >>> 29);
            ang_reg[2] <= ZW'((pc1_reg + RND28) >>> 28);
            ang_reg[3] <= ZW'((pc2_reg + RND28) >>> 28);
            neg3_reg   <= neg2_reg;
        end
    end

    // four rotation chains: dlat, dlon, lat1, lat2
    logic signed [CW-1:0] rx [0:3][0:N];
    logic signed [CW-1:0] ry [0:3][0:N];
    logic signed [ZW-1:0] rz [0:3][0:N];

    genvar ln, st;
    generate
        for (ln = 0; ln < 4; ln++)
        begin : g_rot_lane
            assign rx[ln][0] = gcdu_pkg::CORDIC_INV_GAIN;
            assign ry[ln][0] = '0;
            assign rz[ln][0] = ang_reg[ln];
            for (st = 0; st < N; st++)
            begin : g_rot_step
                gcdu_rot_cell u_cell (
                    .clk   (clk),
                    .en    (adv),
                    .step  (5'(st)),
                    .x_in  (rx[ln][st]),
                    .y_in  (ry[ln][st]),
                    .z_in  (rz[ln][st]),
                    .x_out (rx[ln][st+1]),
                    .y_out (ry[ln][st+1]),
                    .z_out (rz[ln][st+1])
                );
            end
        end
    endgenerate

    // cosine sign flags riding alongside the rotation chains
    logic [1:0] negd_reg [0:N-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            negd_reg[0] <= neg3_reg;
            for (int k = 1; k < N; k++)
                negd_reg[k] <= negd_reg[k-1];
        end
    end

    // squares and cosine product
    logic signed [31:0] sl, sn, cs1, cs2;
    logic signed [63:0] msl, msn, mcc;
    logic signed [31:0] sl2_reg, sn2_reg, cc_reg;

    always_comb
    begin
        sl  = ry[0][N][31:0];
        sn  = ry[1][N][31:0];
        cs1 = negd_reg[N-1][0] ? -rx[2][N][31:0] : rx[2][N][31:0];
        cs2 = negd_reg[N-1][1] ? -rx[3][N][31:0] : rx[3][N][31:0];
        msl = 64'(sl) * 64'(sl);
        msn = 64'(sn) * 64'(sn);
        mcc = 64'(cs1) * 64'(cs2);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sl2_reg <= 32'((msl + RND30) >>> 30);
            sn2_reg <= 32'((msn + RND30) >>> 30);
            cc_reg  <= 32'((mcc + RND30) >>> 30);
        end
    end

    // longitude term
    logic signed [63:0] mt;
    logic signed [31:0] t_reg, sl2d_reg;

    assign mt = 64'(cc_reg) * 64'(sn2_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg    <= 32'((mt + RND30) >>> 30);
            sl2d_reg <= sl2_reg;
        end
    end

    // haversine a clamped into [0, 1]
    logic signed [33:0] asum;
    logic [30:0] a_next, a_reg, am_reg;

    always_comb
    begin
        asum = 34'(sl2d_reg) + 34'(t_reg);
        priority if (asum < 0)
            a_next = '0;
        else if (asum > 34'(gcdu_pkg::Q30_ONE))
            a_next = gcdu_pkg::Q30_ONE;
        else
            a_next = asum[30:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg  <= a_next;
            am_reg <= gcdu_pkg::Q30_ONE - a_next;
        end
    end

    // two square root chains: sqrt(a) and sqrt(1-a)
    logic [RW-1:0] qrem  [0:1][0:32];
    logic [31:0]   qroot [0:1][0:32];
    logic [VW-1:0] qv    [0:1][0:32];

    assign qv[0][0] = {3'b000, a_reg, 30'd0};
    assign qv[1][0] = {3'b000, am_reg, 30'd0};

    generate
        for (ln = 0; ln < 2; ln++)
        begin : g_sqrt_lane
            assign qrem[ln][0]  = '0;
            assign qroot[ln][0] = '0;
            for (st = 0; st < 32; st++)
            begin : g_sqrt_step
                gcdu_sqrt_cell u_cell (
                    .clk      (clk),
                    .en       (adv),
                    .rem_in   (qrem[ln][st]),
                    .root_in  (qroot[ln][st]),
                    .v_in     (qv[ln][st]),
                    .rem_out  (qrem[ln][st+1]),
                    .root_out (qroot[ln][st+1]),
                    .v_out    (qv[ln][st+1])
                );
            end
        end
    endgenerate

    // atan2 chain
    logic signed [CW-1:0] vx [0:N];
    logic signed [CW-1:0] vy [0:N];
    logic signed [ZW-1:0] vz [0:N];

    assign vx[0] = CW'({4'b0000, qroot[1][32]});
    assign vy[0] = CW'({4'b0000, qroot[0][32]});
    assign vz[0] = '0;

    generate
        for (st = 0; st < N; st++)
        begin : g_vec_step
            gcdu_vec_cell u_cell (
                .clk   (clk),
                .en    (adv),
                .step  (5'(st)),
                .x_in  (vx[st]),
                .y_in  (vy[st]),
                .z_in  (vz[st]),
                .x_out (vx[st+1]),
                .y_out (vy[st+1]),
                .z_out (vz[st+1])
            );
        end
    endgenerate

    // central angle: clamp to [0, pi/2] and double
    logic signed [ZW-1:0] zc;
    logic [31:0] angle_reg, angle_d_reg;

    always_comb
    begin
        priority if (vz[N] < 0)
            zc = '0;
        else if (vz[N] > gcdu_pkg::HALF_PI_Q30)
            zc = gcdu_pkg::HALF_PI_Q30;
        else
            zc = vz[N];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            angle_reg <= {zc[30:0], 1'b0};
    end

    // angle times radius
    logic [55:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg    <= 56'(angle_reg) * 56'(radius_reg);
            angle_d_reg <= angle_reg;
        end
    end

    // output register with rounding and saturation
    logic [55:0] dist_full;
    logic [33:0] dist_next, dist_reg;
    logic [31:0] angle_out_reg;

    always_comb
    begin
        dist_full = (prod_reg + RND22) >> 22;
        if (dist_full > 56'(gcdu_pkg::DIST_MAX))
            dist_next = gcdu_pkg::DIST_MAX;
        else
            dist_next = dist_full[33:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dist_reg      <= dist_next;
            angle_out_reg <= angle_d_reg;
        end
    end

    assign central_angle = angle_out_reg;
    assign distance_m    = dist_reg;

    // checks
    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[gcdu_pkg::ST_A] |-> (a_reg <= gcdu_pkg::Q30_ONE)
        && (32'(a_reg) + 32'(am_reg) == 32'(gcdu_pkg::Q30_ONE)))
        else $error("haversine term out of range");

    angle_even: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[gcdu_pkg::ST_ANGLE] |-> (angle_reg[0] == 1'b0))
        else $error("doubled angle has low bit set");

    angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (central_angle <= gcdu_pkg::PI_Q30))
        else $error("central angle above pi");

    dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (distance_m <= gcdu_pkg::DIST_MAX))
        else $error("distance above saturation limit");

    zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && central_angle == 32'd0) |-> (distance_m == 34'd0))
        else $error("nonzero distance for zero angle");

endmodule

`default_nettype wire

FILE: verif/great_circle_distance_checker.sv
`timescale 1ns / 100ps

module great_circle_distance_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               radius_we,
    input  wire logic [23:0]        radius_wdata,
    input  wire logic               item_valid,
    input  wire logic               item_stall,
    input  wire logic signed [30:0] first_lat,
    input  wire logic signed [31:0] first_lon,
    input  wire logic signed [30:0] second_lat,
    input  wire logic signed [31:0] second_lon,
    input  wire logic               result_valid,
    input  wire logic               result_stall,
    input  wire logic [31:0]        central_angle,
    input  wire logic [33:0]        distance_m,
    output int                      errors,
    output int                      outstanding,
    output int                      words_checked
);

    typedef struct packed {
        logic [31:0] angle;
        logic [33:0] dist_q8;
    } span_t;

    localparam longint DEG_90     = 64'sd754974720;
    localparam longint DEG_180    = 64'sd1509949440;
    localparam longint DEG_360    = 64'sd3019898880;
    localparam longint RAD_SCALE  = 64'sd599690565;
    localparam longint INV_GAIN   = 64'sd652032874;
    localparam longint ONE_Q30    = 64'sd1073741824;
    localparam longint HALF_PI    = 64'sd1686629713;
    localparam longint PI_VAL     = 64'sd3373259426;
    localparam longint DIST_LIMIT = 64'sd13493037000;

    // arctangent of 2^-i, q2.30
    localparam longint ARCTAN [32] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
        131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
        128, 64, 32, 16, 8, 4, 2, 1, 0};

    logic [23:0] radius;
    span_t       span_q[$];

    function automatic longint wrap360(longint d);
        longint m;
        m = (d + DEG_180) % DEG_360;
        if (m < 0)
            m += DEG_360;
        return m - DEG_180;
    endfunction

    function automatic longint to_rad(longint d, int sh);
        return (d * RAD_SCALE + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    // rotation mode: returns cosine and sine of z
    function automatic void rotate(longint z, output longint c, output longint s);
        longint x, y, dx, dy;
        x = INV_GAIN;
        y = 0;
        for (int i = 0; i < gcdu_pkg::CORDIC_ITERATIONS && i < 32; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= ARCTAN[i];
            end
            else
            begin
                x += dx; y -= dy; z += ARCTAN[i];
            end
        end
        c = x;
        s = y;
    endfunction

    // vectoring mode: angle of (x, y)
    function automatic longint vector_angle(longint y, longint x);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < gcdu_pkg::CORDIC_ITERATIONS && i < 32; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx; y -= dy; z += ARCTAN[i];
            end
            else
            begin
                x -= dx; y += dy; z -= ARCTAN[i];
            end
        end
        return z;
    endfunction

    function automatic longint root_floor(longint unsigned v);
        longint unsigned rem, root, t;
        rem = 0;
        root = 0;
        for (int i = 0; i < 32; i++)
        begin
            root = root << 1;
            rem = (rem << 2) | (v >> 62);
            v = v << 2;
            t = (root << 1) | 1;
            if (rem >= t)
            begin
                rem -= t;
                root |= 1;
            end
        end
        return longint'(root);
    endfunction

    // cosine of a latitude, folded beyond the poles
    function automatic longint lat_cosine(longint lat);
        longint r, c, s;
        bit neg;
        r = wrap360(lat);
        neg = 1'b0;
        if (r > DEG_90)
        begin
            r = DEG_180 - r; neg = 1'b1;
        end
        else if (r < -DEG_90)
        begin
            r = -DEG_180 - r; neg = 1'b1;
        end
        rotate(to_rad(r, 28), c, s);
        return neg ? -c : c;
    endfunction

    function automatic longint half_sine(longint d);
        longint c, s;
        rotate(to_rad(wrap360(d), 29), c, s);
        return s;
    endfunction

    function automatic span_t haversine_span(longint lat1, longint lon1, longint lat2,
                                             longint lon2, logic [23:0] rad);
        longint sl, sn, cc, a, sy, sx, z;
        longint unsigned dist_val;
        span_t r;
        sl = half_sine(lat2 - lat1);
        sn = half_sine(lon2 - lon1);
        cc = qmul(lat_cosine(lat1), lat_cosine(lat2));
        a = qmul(sl, sl) + qmul(cc, qmul(sn, sn));
        if (a < 0)
            a = 0;
        if (a > ONE_Q30)
            a = ONE_Q30;
        sy = root_floor(longint'(a) << 30);
        sx = root_floor(longint'(ONE_Q30 - a) << 30);
        z = vector_angle(sy, sx);
        if (z < 0)
            z = 0;
        if (z > HALF_PI)
            z = HALF_PI;
        z = z * 2;
        if (z > PI_VAL)
            z = PI_VAL;
        dist_val = (longint'(z) * longint'({40'd0, rad}) + (64'd1 << 21)) >> 22;
        if (dist_val > DIST_LIMIT)
            dist_val = DIST_LIMIT;
        r.angle = z[31:0];
        r.dist_q8 = dist_val[33:0];
        return r;
    endfunction

    assign outstanding = span_q.size();

    // track radius, queue predictions, compare results
    always @(posedge clk or negedge rst_n)
    begin
        span_t want;
        if (!rst_n)
        begin
            radius <= gcdu_pkg::RADIUS_RESET;
            errors = 0;
            words_checked = 0;
            span_q.delete();
        end
        else
        begin
            if (radius_we)
                radius <= radius_wdata;
            if (result_valid && !result_stall)
            begin
                if (span_q.size() == 0)
                begin
                    $error("unexpected result word: angle %0d dist %0d",
                           central_angle, distance_m);
                    errors++;
                end
                else
                begin
                    want = span_q.pop_front();
                    words_checked++;
                    if (central_angle !== want.angle)
                    begin
                        $error("central_angle expected %0d actual %0d",
                               want.angle, central_angle);
                        errors++;
                    end
                    if (distance_m !== want.dist_q8)
                    begin
                        $error("distance_m expected %0d actual %0d",
                               want.dist_q8, distance_m);
                        errors++;
                    end
                end
            end
            if (item_valid && !item_stall)
                span_q.push_back(haversine_span(first_lat, first_lon, second_lat,
                                                second_lon, radius));
        end
    end

endmodule

FILE: verif/great_circle_distance_unit_tb.sv
`timescale 1ns / 100ps

module great_circle_distance_unit_tb;

    localparam int LAT_MAX = 754974720;
    localparam int LON_MAX = 1509949440;
    localparam int DRAIN_CYCLES = 120;
    localparam int HOLD_CYCLES = 400;

    logic               clk;
    logic               rst_n;
    logic               radius_we;
    logic [23:0]        radius_wdata;
    logic               item_valid;
    logic               item_stall;
    logic signed [30:0] first_lat;
    logic signed [31:0] first_lon;
    logic signed [30:0] second_lat;
    logic signed [31:0] second_lon;
    logic               result_valid;
    logic               result_stall;
    logic [31:0]        central_angle;
    logic [33:0]        distance_m;

    int errors;
    int outstanding;
    int words_checked;
    int words_sent;
    int stall_mode;
    bit hold_req;

    great_circle_distance_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .radius_we     (radius_we),
        .radius_wdata  (radius_wdata),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .first_lat     (first_lat),
        .first_lon     (first_lon),
        .second_lat    (second_lat),
        .second_lon    (second_lon),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .central_angle (central_angle),
        .distance_m    (distance_m)
    );

    great_circle_distance_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .radius_we     (radius_we),
        .radius_wdata  (radius_wdata),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .first_lat     (first_lat),
        .first_lon     (first_lon),
        .second_lat    (second_lat),
        .second_lon    (second_lon),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .central_angle (central_angle),
        .distance_m    (distance_m),
        .errors        (errors),
        .outstanding   (outstanding),
        .words_checked (words_checked)
    );

    // clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // run limit
    initial
    begin
        #(20 * 600000);
        $display("[great_circle_distance_unit] ERROR");
        $finish;
    end

    // receiver stall pattern with an occasional long hold
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                result_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                result_stall = 1'b0;
            end
            else
            begin
                case (stall_mode)
                    0: result_stall = 1'b0;
                    1: result_stall = ($urandom_range(0, 99) < 30);
                    default: result_stall = ($urandom_range(0, 99) < 70);
                endcase
            end
        end
    end

    // offer one word and wait until it is taken
    task automatic send_pair(int lat1, int lon1, int lat2, int lon2);
        first_lat = 31'(lat1);
        first_lon = 32'(lon1);
        second_lat = 31'(lat2);
        second_lon = 32'(lon2);
        item_valid = 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic pause_sender(int n);
        item_valid = 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // drain the pipeline, then write the radius
    task automatic set_radius(logic [23:0] r);
        item_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        radius_we = 1'b1;
        radius_wdata = r;
        @(negedge clk);
        radius_we = 1'b0;
    endtask

    function automatic int rand_lat();
        return int'(longint'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX);
    endfunction

    function automatic int rand_lon();
        return int'(longint'($urandom_range(0, 32'(2 * longint'(LON_MAX)))) - LON_MAX);
    endfunction

    task automatic random_pair();
        int kind, lat1, lon1, lat2, lon2;
        kind = $urandom_range(0, 9);
        lat1 = rand_lat();
        lon1 = rand_lon();
        lat2 = rand_lat();
        lon2 = rand_lon();
        case (kind)
            // nearby points
            6:
            begin
                lat2 = lat1 + $signed($urandom_range(0, 2000000)) - 1000000;
                lon2 = lon1 + $signed($urandom_range(0, 2000000)) - 1000000;
                if (lat2 > LAT_MAX) lat2 = LAT_MAX;
                if (lat2 < -LAT_MAX) lat2 = -LAT_MAX;
            end
            // any bit pattern, out-of-range angles included
            7:
            begin
                lat1 = int'($signed(31'($urandom)));
                lat2 = int'($signed(31'($urandom)));
                lon1 = int'($urandom);
                lon2 = int'($urandom);
            end
            // near antipodal
            8:
            begin
                lat2 = -lat1 + $signed($urandom_range(0, 200)) - 100;
                lon2 = lon1 + LON_MAX + $signed($urandom_range(0, 200)) - 100;
            end
            default: ;
        endcase
        send_pair(lat1, lon1, lat2, lon2);
    endtask

    task automatic random_phase(int n);
        int left;
        left = n;
        while (left > 0)
        begin
            for (int b = $urandom_range(1, 24); b > 0 && left > 0; b--)
            begin
                random_pair();
                left--;
            end
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 8));
            if ($urandom_range(0, 30) == 0)
                stall_mode = $urandom_range(0, 2);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        radius_we = 1'b0;
        radius_wdata = '0;
        item_valid = 1'b0;
        first_lat = '0;
        first_lon = '0;
        second_lat = '0;
        second_lon = '0;
        words_sent = 0;
        stall_mode = 0;
        hold_req = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: identical, antipodal, poles, wraps, field extremes
        send_pair(0, 0, 0, 0);
        send_pair(100000, 200000, 100000, 200000);
        send_pair(0, 0, 0, LON_MAX);
        send_pair(0, -LON_MAX, 0, LON_MAX);
        send_pair(LAT_MAX, 0, -LAT_MAX, 0);
        send_pair(LAT_MAX, 123456, LAT_MAX, -987654);
        send_pair(-LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
        send_pair(0, LON_MAX - 1000, 0, -LON_MAX + 1000);
        send_pair(1073741823, 0, -1073741824, 0);
        send_pair(-1073741824, 2147483647, 1073741823, -2147483648);
        send_pair(0, 2147483647, 0, -2147483648);
        send_pair(LAT_MAX + 1000, 0, LAT_MAX - 1000, 0);
        send_pair(0, 0, 1, 1);
        send_pair(-1, -1, 0, 0);
        send_pair(LAT_MAX / 2, LON_MAX / 3, -LAT_MAX / 4, -LON_MAX / 2);
        pause_sender(3);
        random_phase(200);

        // radius extremes, saturation and zero
        set_radius(24'd16777215);
        send_pair(0, 0, 0, LON_MAX);
        send_pair(LAT_MAX, 0, -LAT_MAX, 0);
        stall_mode = 1;
        random_phase(250);
        set_radius(24'd1);
        send_pair(0, 0, 0, LON_MAX);
        random_phase(250);
        set_radius(24'd0);
        send_pair(0, 0, 0, LON_MAX);
        random_phase(100);

        // long receiver hold while the sender keeps offering
        set_radius(24'($urandom_range(1, 16777215)));
        stall_mode = 0;
        hold_req = 1'b1;
        random_phase(300);
        stall_mode = 2;
        random_phase(200);

        // sender waits until every result is back
        item_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        set_radius(24'd6371000);
        stall_mode = 1;
        random_phase(430);

        pause_sender(0);
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("sent %0d position pairs over six radius settings (zero, one, max, random, default)",
                 words_sent);
        $display("checked %0d result words with random stalls and a long hold",
                 words_checked);
        if (errors == 0)
            $display("[great_circle_distance_unit] OK");
        else
            $display("[great_circle_distance_unit] ERROR");
        $finish;
    end

endmodule

FILE: great_circle_distance_unit.f
src/gcdu_pkg.sv
src/gcdu_rot_cell.sv
src/gcdu_vec_cell.sv
src/gcdu_sqrt_cell.sv
src/great_circle_distance_unit.sv
verif/great_circle_distance_checker.sv
verif/great_circle_distance_unit_tb.sv
